// ----- hw/rtl/lbt_pkg.sv -----
package lbt_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_THICKNESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMISSIVITY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COSINE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SURF_TEMP  = 3'd3;

	localparam int DEF_MAX_LAYERS = 64;

	// exp(-x) tables, Q1.32 with 1.0 = 2^32
	typedef logic [16:0][32:0] tab_arr_t;

	// shift and subtract quotient, used only while building the tables
	function automatic logic [127:0] const_quo(input logic [127:0] num,
			input logic [127:0] den);
		logic [127:0] q;
		logic [127:0] r;
		q = '0;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			r = {r[126:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tab_arr_t calc_frac_tab();
		tab_arr_t       t;
		logic [127:0]   pos;
		logic [127:0]   neg;
		logic [127:0]   term;
		logic [127:0]   e16;
		logic [127:0]   prod;
		pos  = 128'd1 << 32;
		neg  = '0;
		term = 128'd1 << 32;
		for (int m = 1; m < 16; m++) begin
			if (term != 0) begin
				term = const_quo(term, 128'(m) << 4);
				if ((m & 1) == 1) neg = neg + term;
				else pos = pos + term;
			end
		end
		e16  = pos - neg;
		t[0] = 33'h1_0000_0000;
		for (int j = 1; j <= 16; j++) begin
			prod = ({95'd0, t[j-1]} * e16 + (128'd1 << 31)) >> 32;
			t[j] = prod[32:0];
		end
		return t;
	endfunction

	function automatic tab_arr_t calc_int_tab();
		tab_arr_t       f;
		tab_arr_t       t;
		logic [127:0]   prod;
		f    = calc_frac_tab();
		t[0] = 33'h1_0000_0000;
		for (int j = 1; j <= 16; j++) begin
			prod = ({95'd0, t[j-1]} * {95'd0, f[16]} + (128'd1 << 31)) >> 32;
			t[j] = prod[32:0];
		end
		return t;
	endfunction

	localparam tab_arr_t FRAC_TAB = calc_frac_tab();
	localparam tab_arr_t INT_TAB  = calc_int_tab();

	// sequencer states
	typedef enum logic [20:0] {
		ST_IDLE = 21'd1 << 0,
		ST_DIV  = 21'd1 << 1,
		ST_READ = 21'd1 << 2,
		ST_MH   = 21'd1 << 3,
		ST_AH   = 21'd1 << 4,
		ST_EX1  = 21'd1 << 5,
		ST_EX2  = 21'd1 << 6,
		ST_EX3  = 21'd1 << 7,
		ST_EXR  = 21'd1 << 8,
		ST_MW   = 21'd1 << 9,
		ST_MT   = 21'd1 << 10,
		ST_MP   = 21'd1 << 11,
		ST_ACC  = 21'd1 << 12,
		ST_MS1  = 21'd1 << 13,
		ST_MS2  = 21'd1 << 14,
		ST_SACC = 21'd1 << 15,
		ST_DONE = 21'd1 << 16
	} state_t;

endpackage

// ----- hw/rtl/layered_brightness_temperature.sv -----
// channel | signals                                        | direction
// input   | in_valid/in_ready, layer_absorption,           | in
//         | layer_temperature, is_last_layer               |
// output  | out_valid/out_ready, brightness_temp,          | out
//         | profile_overflow                               |
// config  | cfg_we, cfg_index, cfg_wdata                   | in
// A layer that is not the last is taken while the block is idle.
// The last layer starts the profile run: the dz2 divider, then each layer on
// the way down, the surface, each layer on the way up; the layer steps share
// the one multiplier.
// Input ready stays low through the run; a held result stalls the next one.
// Reset clears the layer count and accumulators and loads config defaults.
module layered_brightness_temperature #(
	parameter int MAX_LAYERS = lbt_pkg::DEF_MAX_LAYERS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [23:0]                       layer_absorption,
	input  logic [23:0]                       layer_temperature,
	input  logic                              is_last_layer,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [23:0]                       brightness_temp,
	output logic                              profile_overflow,
	input  logic                              cfg_we,
	input  logic [lbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import lbt_pkg::*;

	localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int CW = $clog2(MAX_LAYERS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LAYERS);

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [34:0] b);
		logic [35:0] s;
		s = {4'd0, a} + {1'b0, b};
		return (s > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	state_t state_q;

	logic [23:0] dz_q;
	logic [16:0] eps_q;
	logic [16:0] umu_q;
	logic [23:0] ts_q;

	logic [47:0] store_mem [MAX_LAYERS];
	logic [47:0] rd_q;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	logic          pass2_q;
	logic          surf_q;

	logic [31:0] att_q;
	logic [31:0] tb_q;
	logic [31:0] h_q;
	logic [24:0] f24_q;
	logic [24:0] e_q;
	logic [23:0] dz2_q;

	logic [18:0] rem_q;
	logic [39:0] quo_q;
	logic [17:0] dvs_q;
	logic [5:0]  div_cnt_q;

	logic          out_valid_q;
	logic [23:0]   out_tb_q;
	logic          out_ovf_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] p_q;

	logic              in_acc;
	logic [16:0]       eps_eff;
	logic [16:0]       weight;
	logic [7:0]        ex_n;
	logic [3:0]        ex_j;
	logic [19:0]       ex_r;
	logic              ex_zero;
	logic [4:0]        ex_ni;
	logic [32:0]       frac;
	logic [33:0]       frac_rnd;
	logic [19:0]       rem_sh;
	logic              rem_ge;
	logic [CW-1:0]     last_idx;
	logic [PROD_W-1:0] e_rnd;
	logic [33:0]       term;

	assign in_ready         = (state_q == ST_IDLE);
	assign in_acc           = in_valid && in_ready;
	assign out_valid        = out_valid_q;
	assign brightness_temp  = out_tb_q;
	assign profile_overflow = out_ovf_q;

	assign eps_eff  = (eps_q > 17'd65536) ? 17'd65536 : eps_q;
	assign weight   = 17'd65536 - eps_eff;
	assign last_idx = cnt_q - CW'(1);

	// split the optical depth for the exp lookup
	assign ex_n    = att_q[31:24];
	assign ex_j    = att_q[23:20];
	assign ex_r    = att_q[19:0];
	assign ex_zero = (ex_n >= 8'd17);
	assign ex_ni   = ex_zero ? 5'd0 : ex_n[4:0];
	assign frac    = FRAC_TAB[ex_j] - p_q[52:20];
	assign frac_rnd = {1'b0, frac} + 34'd128;
	assign e_rnd   = p_q + (PROD_W'(1) << 31);
	assign term    = pass2_q ? p_q[49:16] : p_q[57:24];

	// one restoring divide step
	assign rem_sh = {rem_q, quo_q[39]};
	assign rem_ge = (rem_sh >= {2'b0, dvs_q});

	// select the shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MH: begin
				mul_a = MUL_W'(rd_q[47:24]);
				mul_b = MUL_W'(dz2_q);
			end
			ST_EX1: begin
				mul_a = MUL_W'(FRAC_TAB[ex_j] - FRAC_TAB[5'(ex_j) + 5'd1]);
				mul_b = MUL_W'(ex_r);
			end
			ST_EX3: begin
				mul_a = MUL_W'(INT_TAB[ex_ni]);
				mul_b = MUL_W'(f24_q);
			end
			ST_MW: begin
				mul_a = MUL_W'({h_q, 1'b0});
				mul_b = MUL_W'(e_q);
			end
			ST_MT: begin
				mul_a = p_q[57:24];
				mul_b = MUL_W'(rd_q[23:0]);
			end
			ST_MP: begin
				mul_a = p_q[57:24];
				mul_b = MUL_W'(weight);
			end
			ST_MS1: begin
				mul_a = MUL_W'(ts_q);
				mul_b = MUL_W'(e_q);
			end
			ST_MS2: begin
				mul_a = MUL_W'(p_q[48:24]);
				mul_b = MUL_W'(eps_eff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	lbt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q  <= 24'd65536;
			eps_q <= 17'd65536;
			umu_q <= 17'd65536;
			ts_q  <= 24'd4915200;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THICKNESS:  dz_q  <= cfg_wdata;
				REG_EMISSIVITY: eps_q <= cfg_wdata[16:0];
				REG_COSINE:     umu_q <= cfg_wdata[16:0];
				REG_SURF_TEMP:  ts_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// write layers in, read one back per step
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < MAX_CNT))
			store_mem[cnt_q[AW-1:0]] <= {layer_absorption, layer_temperature};
		if (state_q == ST_READ)
			rd_q <= store_mem[idx_q];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_AH:  h_q   <= (p_q[47:8] > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : p_q[39:8];
			ST_EX2: f24_q <= frac_rnd[32:8];
			ST_EXR: e_q   <= ex_zero ? 25'd0 : e_rnd[56:32];
			default: ;
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			pass2_q     <= 1'b0;
			surf_q      <= 1'b0;
			att_q       <= '0;
			tb_q        <= '0;
			dz2_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			dvs_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_tb_q    <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_DONE))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cnt_q < MAX_CNT) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
						if (is_last_layer) begin
							state_q   <= ST_DIV;
							rem_q     <= '0;
							quo_q     <= {dz_q, 16'd0};
							dvs_q     <= (umu_q == 17'd0) ? 18'd2 : {umu_q, 1'b0};
							div_cnt_q <= '0;
							att_q     <= '0;
							tb_q      <= '0;
							pass2_q   <= 1'b0;
							surf_q    <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= rem_ge ? 19'(rem_sh - {2'b0, dvs_q}) : rem_sh[18:0];
					quo_q     <= {quo_q[38:0], rem_ge};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd39) begin
						state_q <= ST_READ;
						idx_q   <= last_idx[AW-1:0];
					end
				end
				ST_READ: begin
					if (div_cnt_q == 6'd40) begin
						dz2_q     <= (quo_q[39:24] != 16'd0) ? 24'hFF_FFFF : quo_q[23:0];
						div_cnt_q <= 6'd0;
					end
					state_q <= ST_MH;
				end
				ST_MH:  state_q <= ST_AH;
				ST_AH: begin
					att_q   <= sat_add(att_q,
						(p_q[47:8] > 40'hFFFF_FFFF) ? 35'h0_FFFF_FFFF : 35'(p_q[39:8]));
					state_q <= ST_EX1;
				end
				ST_EX1: state_q <= ST_EX2;
				ST_EX2: state_q <= ST_EX3;
				ST_EX3: state_q <= ST_EXR;
				ST_EXR: state_q <= surf_q ? ST_MS1 : ST_MW;
				ST_MW:  state_q <= ST_MT;
				ST_MT:  state_q <= pass2_q ? ST_MP : ST_ACC;
				ST_MP:  state_q <= ST_ACC;
				ST_ACC: begin
					tb_q  <= sat_add(tb_q, {1'b0, term});
					att_q <= sat_add(att_q, {3'd0, h_q});
					if (!pass2_q) begin
						if (idx_q == '0) begin
							surf_q  <= 1'b1;
							state_q <= ST_EX1;
						end else begin
							idx_q   <= idx_q - AW'(1);
							state_q <= ST_READ;
						end
					end else begin
						if (idx_q == last_idx[AW-1:0]) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_MS1: state_q <= ST_MS2;
				ST_MS2: state_q <= ST_SACC;
				ST_SACC: begin
					tb_q    <= sat_add(tb_q, 35'(p_q[41:16]));
					surf_q  <= 1'b0;
					pass2_q <= 1'b1;
					idx_q   <= '0;
					state_q <= ST_READ;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_tb_q    <= (tb_q > 32'h00FF_FFFF) ? 24'hFF_FFFF : tb_q[23:0];
						out_ovf_q   <= ovf_q;
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						att_q       <= '0;
						tb_q        <= '0;
						pass2_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the layer count never runs past the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("layer count beyond store depth");

	// a last layer starts the divider at once
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_last_layer) |=> (state_q == ST_DIV))
		else $error("last layer did not start the run");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_tb_q)))
		else $error("held result changed");

	// exp of the optical depth never exceeds one
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MW) |-> (e_q <= 25'h100_0000))
		else $error("exp value out of range");

endmodule

// ----- hw/rtl/lbt_mul.sv -----
module lbt_mul (
	input  logic                          clk,
	input  logic [lbt_pkg::MUL_W-1:0]     a,
	input  logic [lbt_pkg::MUL_W-1:0]     b,
	output logic [lbt_pkg::PROD_W-1:0]    p_q
);
	import lbt_pkg::*;

	// register every product before it is used again
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	import lbt_pkg::*;

	localparam int DEPTH = DEF_MAX_LAYERS;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 80;

	typedef struct packed {
		logic [23:0] temp;
		logic        ovf;
	} tb_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [23:0]           layer_absorption;
	logic [23:0]           layer_temperature;
	logic                  is_last_layer;
	logic                  out_valid;
	logic                  out_ready;
	logic [23:0]           brightness_temp;
	logic                  profile_overflow;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	layered_brightness_temperature u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.layer_absorption(layer_absorption), .layer_temperature(layer_temperature),
		.is_last_layer(is_last_layer),
		.out_valid(out_valid), .out_ready(out_ready),
		.brightness_temp(brightness_temp), .profile_overflow(profile_overflow),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow registers and profile state
	logic [23:0] thick_q, surf_t_q;
	logic [16:0] emis_q, cos_q;
	logic [23:0] k_mem [DEPTH];
	logic [23:0] t_mem [DEPTH];
	int          layers_held;
	logic        dropped;
	logic [63:0] depth_acc, tb_acc;
	logic [63:0] ftab [17];
	logic [63:0] gtab [17];

	tb_result_t  pending_tb[$];
	int          errors;
	int          snd_idle, rcv_idle;
	int          hold_req, hold_left;
	int          quiet_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// exp(-x) tables, built from the series for exp(-1/16)
	task automatic build_exp_tables();
		logic [63:0] pos, neg, term;
		logic [63:0] e16;
		pos  = 64'd1 << 32;
		neg  = 0;
		term = 64'd1 << 32;
		for (int m = 1; m < 16 && term != 0; m++) begin
			term = term / (16 * m);
			if (m % 2) neg += term;
			else pos += term;
		end
		e16 = pos - neg;
		ftab[0] = 64'd1 << 32;
		for (int j = 1; j <= 16; j++)
			ftab[j] = (ftab[j-1] * e16 + (64'd1 << 31)) >> 32;
		gtab[0] = 64'd1 << 32;
		for (int j = 1; j <= 16; j++)
			gtab[j] = (gtab[j-1] * ftab[16] + (64'd1 << 31)) >> 32;
	endtask

	function automatic logic [63:0] decay(logic [63:0] att);
		logic [63:0] n, f, j, r, fr, f24;
		n = att >> 24;
		f = att & 64'hFF_FFFF;
		if (n >= 17) return 0;
		j   = f >> 20;
		r   = f & 64'hF_FFFF;
		fr  = ftab[j] - (((ftab[j] - ftab[j+1]) * r) >> 20);
		f24 = (fr + 128) >> 8;
		return (gtab[n] * f24 + (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	function automatic void emit_layer(logic [23:0] k, logic [23:0] t, logic [63:0] dz2,
			logic [63:0] weight);
		logic [63:0] h, w, term;
		h = (64'(k) * dz2) >> 8;
		if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
		depth_acc = add_sat(depth_acc, h);
		w    = (2 * h * decay(depth_acc)) >> 24;
		term = (w * 64'(t)) >> 24;
		term = (term * weight) >> 16;
		tb_acc    = add_sat(tb_acc, term);
		depth_acc = add_sat(depth_acc, h);
	endfunction

	// take one layer; on the top layer work out the brightness temperature
	function automatic void absorb_layer(logic [23:0] k, logic [23:0] t, logic last);
		logic [63:0] umu, eps, dz2, surf;
		tb_result_t  res;
		if (layers_held < DEPTH) begin
			k_mem[layers_held] = k;
			t_mem[layers_held] = t;
			layers_held++;
		end else begin
			dropped = 1'b1;
		end
		if (!last) return;
		umu = (cos_q == 0) ? 64'd1 : 64'(cos_q);
		eps = (emis_q > 17'd65536) ? 64'd65536 : 64'(emis_q);
		dz2 = (64'(thick_q) << 16) / (2 * umu);
		if (dz2 > 64'hFF_FFFF) dz2 = 64'hFF_FFFF;
		depth_acc = 0;
		tb_acc    = 0;
		for (int i = layers_held - 1; i >= 0; i--)
			emit_layer(k_mem[i], t_mem[i], dz2, 64'd65536);
		surf   = (((64'(surf_t_q) * decay(depth_acc)) >> 24) * eps) >> 16;
		tb_acc = add_sat(tb_acc, surf);
		for (int i = 0; i < layers_held; i++)
			emit_layer(k_mem[i], t_mem[i], dz2, 64'd65536 - eps);
		res.temp = (tb_acc > 64'hFF_FFFF) ? 24'hFF_FFFF : tb_acc[23:0];
		res.ovf  = dropped;
		pending_tb.push_back(res);
		layers_held = 0;
		dropped     = 1'b0;
	endfunction

	// offer one request and hold it until taken
	task automatic send_layer(logic [23:0] k, logic [23:0] t, logic last);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		layer_absorption  <= k;
		layer_temperature <= t;
		is_last_layer     <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_layer(k, t, last);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tb.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write only while the block sits idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THICKNESS:  thick_q  = val;
			REG_EMISSIVITY: emis_q   = val[16:0];
			REG_COSINE:     cos_q    = val[16:0];
			REG_SURF_TEMP:  surf_t_q = val;
			default: ;
		endcase
	endtask

	function automatic logic [23:0] pick_k();
		case ($urandom_range(3))
			0: return 24'($urandom_range(24'hFF_FFFF));
			1: return 24'($urandom_range(24'h00_0FFF));
			default: return 24'($urandom_range(24'h03_FFFF));
		endcase
	endfunction

	// send a profile of n layers; pick_len makes most short, now and then a full or overflowing one
	task automatic send_profile(int n);
		for (int i = 0; i < n; i++)
			send_layer(pick_k(), 24'($urandom_range(24'hFF_FFFF)), i == n - 1);
	endtask

	function automatic int pick_len();
		int p;
		p = $urandom_range(99);
		if (p < 3) return $urandom_range(DEPTH + 6, DEPTH - 2);
		if (p < 10) return $urandom_range(30, 10);
		return $urandom_range(8, 1);
	endfunction

	task automatic test_directed();
		snd_idle = 0;
		rcv_idle = 0;
		send_layer(24'd0, 24'd0, 1'b1);
		send_layer(24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
		send_layer(24'd0, 24'hFF_FFFF, 1'b1);
		send_layer(24'h00_1000, 24'h4B_0000, 1'b0);
		send_layer(24'h00_8000, 24'h3C_0000, 1'b0);
		send_layer(24'h01_0000, 24'h32_0000, 1'b1);
		send_layer(24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
		send_layer(24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
		send_layer(24'h55_5555, 24'hAA_AAAA, 1'b0);
		send_layer(24'hAA_AAAA, 24'h55_5555, 1'b1);
	endtask

	// profile too long: the top layer itself is dropped, then exactly full, then one over
	task automatic test_overflow();
		for (int i = 0; i < DEPTH + 3; i++)
			send_layer(pick_k(), 24'($urandom_range(24'hFF_FFFF)), i == DEPTH + 2);
		send_profile(DEPTH);
		send_profile(DEPTH + 1);
	endtask

	task automatic test_register_extremes();
		write_reg(REG_THICKNESS, 24'd0);
		send_profile(3);
		write_reg(REG_THICKNESS, 24'hFF_FFFF);
		write_reg(REG_COSINE, 24'd1);
		send_profile(3);
		write_reg(REG_COSINE, 24'd0);
		write_reg(REG_THICKNESS, 24'h00_0100);
		send_profile(4);
		write_reg(REG_EMISSIVITY, 24'd0);
		write_reg(REG_COSINE, 24'd65536);
		send_profile(4);
		write_reg(REG_EMISSIVITY, 24'h01_FFFF);
		write_reg(REG_SURF_TEMP, 24'hFF_FFFF);
		send_profile(2);
		write_reg(REG_SURF_TEMP, 24'd0);
		write_reg(REG_EMISSIVITY, 24'd32768);
		send_profile(2);
		write_reg(REG_NONE, 24'hFF_FFFF);
		send_profile(2);
	endtask

	task automatic test_random(int s_idle, int r_idle, int n_items);
		int sent, n;
		sent = 0;
		write_reg(REG_THICKNESS, 24'($urandom_range(24'h04_0000, 24'h00_1000)));
		write_reg(REG_EMISSIVITY, 24'($urandom_range(65536)));
		write_reg(REG_COSINE, 24'($urandom_range(65536, 1)));
		write_reg(REG_SURF_TEMP, 24'($urandom_range(24'hFF_FFFF)));
		snd_idle = s_idle;
		rcv_idle = r_idle;
		while (sent < n_items) begin
			n = pick_len();
			send_profile(n);
			sent += n;
		end
	endtask

	// hold off the receiver while profiles keep coming, then drain and send one more
	task automatic test_backpressure();
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 400;
		for (int i = 0; i < 6; i++) send_profile($urandom_range(4, 1));
		drain();
		send_profile(3);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// check each result against the oldest prediction
	always @(posedge clk) begin
		tb_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tb.size() == 0) begin
				$error("unexpected result brightness_temp=%0d", brightness_temp);
				errors++;
			end else begin
				want = pending_tb.pop_front();
				if (brightness_temp !== want.temp) begin
					$error("brightness_temp: expected %0d, got %0d", want.temp, brightness_temp);
					errors++;
				end
				if (profile_overflow !== want.ovf) begin
					$error("profile_overflow: expected %0d, got %0d", want.ovf,
						profile_overflow);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("layered_brightness_temperature: mismatch");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		layer_absorption  = '0;
		layer_temperature = '0;
		is_last_layer     = 1'b0;
		out_ready         = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		errors            = 0;
		snd_idle          = 0;
		rcv_idle          = 0;
		hold_req          = 0;
		hold_left         = 0;
		quiet_cycles      = 0;
		thick_q           = 24'd65536;
		emis_q            = 17'd65536;
		cos_q             = 17'd65536;
		surf_t_q          = 24'd4915200;
		layers_held       = 0;
		dropped           = 1'b0;
		build_exp_tables();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_register_extremes();
		test_random(28, 54, 200);
		test_random(54, 28, 200);
		test_random(0, 0, 200);
		test_backpressure();
		drain();

		if (errors == 0)
			$display("layered_brightness_temperature: match");
		else
			$display("layered_brightness_temperature: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/lbt_pkg.sv
hw/rtl/lbt_mul.sv
hw/rtl/layered_brightness_temperature.sv
verif/testbench.sv
